FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the load align/extend unit
// no dependencies; taken in by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/lae_pkg.sv
// types and codes of the load align/extend unit
// no dependencies; used by every module of the unit
`default_nettype none

package lae_pkg;

  typedef enum logic [3:0] {
    OP_LB   = 4'd0,
    OP_LBU  = 4'd1,
    OP_LH   = 4'd2,
    OP_LHU  = 4'd3,
    OP_LW   = 4'd4,
    OP_LWU  = 4'd5,
    OP_LWL  = 4'd6,
    OP_LWR  = 4'd7,
    OP_LD   = 4'd8,
    OP_LDL  = 4'd9,
    OP_LDR  = 4'd10,
    OP_LQ   = 4'd11,
    OP_LUI  = 4'd12,
    OP_LWC1 = 4'd13
  } op_t;

  typedef enum logic [2:0] {
    SZ_BYTE  = 3'd0,
    SZ_HALF  = 3'd1,
    SZ_WORD  = 3'd2,
    SZ_DWORD = 3'd3,
    SZ_QUAD  = 3'd4,
    SZ_NONE  = 3'd5
  } size_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FAULT = 2'd1,
    ST_COP   = 2'd2
  } status_t;

  // one classified load, as handed from the front to the back
  typedef struct packed {
    op_t          op;
    logic [31:0]  addr;
    size_t        size;
    logic         we;
    logic         to_float;
    status_t      status;
    logic [2:0]   boff;
    logic [15:0]  imm;
    logic [63:0]  mem_low;
    logic [63:0]  mem_high;
    logic [63:0]  old_dest;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lae_front.sv
// front of the load align/extend unit: takes requests, forms the address
// and classifies the access; depends on lae_pkg
`default_nettype none

module lae_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output      logic            busy,
  input  wire logic [3:0]      req_type,
  input  wire logic [31:0]     base_value,
  input  wire logic [15:0]     offset_imm,
  input  wire logic [63:0]     mem_low,
  input  wire logic [63:0]     mem_high,
  input  wire logic            mem_fault,
  input  wire logic [63:0]     old_dest,
  input  wire logic            cop_usable,
  input  wire logic            q_full,
  output      logic            push,
  output      lae_pkg::entry_t push_data
);

  logic            fvalid;
  lae_pkg::entry_t entry;
  lae_pkg::entry_t entry_next;
  logic            accept;
  logic [31:0]     ea;
  lae_pkg::op_t    op;

  assign busy   = fvalid && q_full;
  assign accept = start && !busy;
  assign push      = fvalid;
  assign push_data = entry;

  assign op = lae_pkg::op_t'(req_type);
  assign ea = base_value + {{16{offset_imm[15]}}, offset_imm};

  always_comb begin
    entry_next          = '0;
    entry_next.op       = op;
    entry_next.addr     = ea;
    entry_next.size     = lae_pkg::SZ_NONE;
    entry_next.we       = 1'b1;
    entry_next.to_float = (op == lae_pkg::OP_LWC1);
    entry_next.status   = lae_pkg::ST_DONE;
    entry_next.boff     = ea[2:0];
    entry_next.imm      = offset_imm;
    entry_next.mem_low  = mem_low;
    entry_next.mem_high = mem_high;
    entry_next.old_dest = old_dest;
    unique case (op)
      lae_pkg::OP_LB, lae_pkg::OP_LBU: entry_next.size = lae_pkg::SZ_BYTE;
      lae_pkg::OP_LH, lae_pkg::OP_LHU: entry_next.size = lae_pkg::SZ_HALF;
      lae_pkg::OP_LW, lae_pkg::OP_LWU, lae_pkg::OP_LWC1: begin
        entry_next.size = lae_pkg::SZ_WORD;
      end
      lae_pkg::OP_LD: entry_next.size = lae_pkg::SZ_DWORD;
      lae_pkg::OP_LWL, lae_pkg::OP_LWR: begin
        entry_next.size = lae_pkg::SZ_WORD;
        entry_next.addr = {ea[31:2], 2'b00};
      end
      lae_pkg::OP_LDL, lae_pkg::OP_LDR: begin
        entry_next.size = lae_pkg::SZ_DWORD;
        entry_next.addr = {ea[31:3], 3'b000};
      end
      lae_pkg::OP_LQ: begin
        entry_next.size = lae_pkg::SZ_QUAD;
        entry_next.addr = {ea[31:4], 4'b0000};
      end
      lae_pkg::OP_LUI: entry_next.addr = '0;
      default: begin
        entry_next.addr = '0;
        entry_next.we   = 1'b0;
      end
    endcase
    // coprocessor check wins over a memory fault
    if (op == lae_pkg::OP_LWC1 && !cop_usable) begin
      entry_next.addr   = '0;
      entry_next.size   = lae_pkg::SZ_NONE;
      entry_next.we     = 1'b0;
      entry_next.status = lae_pkg::ST_COP;
    end else if (entry_next.size != lae_pkg::SZ_NONE && mem_fault) begin
      entry_next.we     = 1'b0;
      entry_next.status = lae_pkg::ST_FAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      fvalid <= 1'b1;
    end else if (push && !q_full) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lae_queue.sv
// short queue of classified loads between front and back
// depends on lae_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lae_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire lae_pkg::entry_t push_data,
  output      logic            full,
  input  wire logic            pop,
  output      logic            valid,
  output      lae_pkg::entry_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lae_pkg::entry_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push_ok;
  logic              pop_ok;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && valid;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `ASSERT_NEVER(a_count_range, clk, rst, count > CNT_W'(DEPTH), "queue count beyond depth")
  `ASSERT_CLK(a_count_up, clk, rst, (push_ok && !pop_ok) |=> (count == $past(count) + 1'b1), "queue count missed a transfer in")
  `ASSERT_CLK(a_ptr_gap, clk, rst, (count == '0) |-> (wr_ptr == rd_ptr), "queue pointers apart while empty")

endmodule

`default_nettype wire

FILE: hw/rtl/lae_back.sv
// back of the load align/extend unit: aligns, merges and extends the data
// and registers the result; depends on lae_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lae_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire lae_pkg::entry_t in_data,
  output      logic            done,
  output      logic [31:0]     access_address,
  output      logic [2:0]      access_size,
  output      logic            write_enable,
  output      logic            to_float_file,
  output      logic [63:0]     result_low,
  output      logic [63:0]     result_high,
  output      logic [1:0]      status
);

  logic [63:0] rlo;
  logic [63:0] rhi;
  logic [4:0]  sh_w;
  logic [5:0]  sh_d;
  logic [31:0] m_w;
  logic [63:0] m_d;
  logic [31:0] w;
  logic [63:0] mlo;
  logic [63:0] old;

  assign mlo = in_data.mem_low;
  assign old = in_data.old_dest;

  always_comb begin
    rlo  = '0;
    rhi  = '0;
    sh_w = '0;
    sh_d = '0;
    m_w  = '0;
    m_d  = '0;
    w    = '0;
    unique case (in_data.op)
      lae_pkg::OP_LB:  rlo = {{56{mlo[7]}}, mlo[7:0]};
      lae_pkg::OP_LBU: rlo = {56'd0, mlo[7:0]};
      lae_pkg::OP_LH:  rlo = {{48{mlo[15]}}, mlo[15:0]};
      lae_pkg::OP_LHU: rlo = {48'd0, mlo[15:0]};
      lae_pkg::OP_LW:  rlo = {{32{mlo[31]}}, mlo[31:0]};
      lae_pkg::OP_LWU, lae_pkg::OP_LWC1: rlo = {32'd0, mlo[31:0]};
      lae_pkg::OP_LD:  rlo = mlo;
      lae_pkg::OP_LWL: begin
        // bytes 0..o of the word go to the top of the low word
        sh_w = {~in_data.boff[1:0], 3'b000};
        m_w  = (32'hFFFF_FFFF >> sh_w) << sh_w;
        w    = (old[31:0] & ~m_w) | ((mlo[31:0] << sh_w) & m_w);
        rlo  = {{32{w[31]}}, w};
      end
      lae_pkg::OP_LWR: begin
        sh_w = {in_data.boff[1:0], 3'b000};
        m_w  = 32'hFFFF_FFFF >> sh_w;
        w    = (old[31:0] & ~m_w) | ((mlo[31:0] >> sh_w) & m_w);
        rlo  = {{32{w[31]}}, w};
      end
      lae_pkg::OP_LDL: begin
        sh_d = {~in_data.boff, 3'b000};
        m_d  = ({64{1'b1}} >> sh_d) << sh_d;
        rlo  = (old & ~m_d) | ((mlo << sh_d) & m_d);
      end
      lae_pkg::OP_LDR: begin
        sh_d = {in_data.boff, 3'b000};
        m_d  = {64{1'b1}} >> sh_d;
        rlo  = (old & ~m_d) | ((mlo >> sh_d) & m_d);
      end
      lae_pkg::OP_LQ: begin
        rlo = mlo;
        rhi = in_data.mem_high;
      end
      lae_pkg::OP_LUI: rlo = {{32{in_data.imm[15]}}, in_data.imm, 16'd0};
      default: rlo = '0;
    endcase
    if (!in_data.we) begin
      rlo = '0;
      rhi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      access_address <= in_data.addr;
      access_size    <= in_data.size;
      write_enable   <= in_data.we;
      to_float_file  <= in_data.to_float;
      result_low     <= rlo;
      result_high    <= rhi;
      status         <= in_data.status;
    end
  end

  `ASSERT_CLK(a_done_src, clk, rst, done |-> $past(in_valid), "result strobe without a queued load")
  `ASSERT_CLK(a_no_write_zero, clk, rst, (done && !write_enable) |-> (result_low == '0 && result_high == '0), "data left on a suppressed write")
  `ASSERT_CLK(a_cop_no_access, clk, rst, (done && status == lae_pkg::ST_COP) |-> (access_size == lae_pkg::SZ_NONE && access_address == '0 && !write_enable), "access shown for unusable coprocessor")

endmodule

`default_nettype wire

FILE: hw/rtl/load_align_extend_unit.sv
// load align/extend unit: latency 3, done is high in the third cycle after
// the edge that takes start; one load a cycle sustained
// front stage register, queue and result register each add one clock; the
// back never stalls, so busy stays low and a transfer is taken every cycle
// rst (synchronous) empties the front stage and the queue and clears done
`default_nettype none

module load_align_extend_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [3:0]  req_type,
  input  wire logic [31:0] base_value,
  input  wire logic [15:0] offset_imm,
  input  wire logic [63:0] mem_low,
  input  wire logic [63:0] mem_high,
  input  wire logic        mem_fault,
  input  wire logic [63:0] old_dest,
  input  wire logic        cop_usable,
  output      logic        done,
  output      logic [31:0] access_address,
  output      logic [2:0]  access_size,
  output      logic        write_enable,
  output      logic        to_float_file,
  output      logic [63:0] result_low,
  output      logic [63:0] result_high,
  output      logic [1:0]  status
);

  logic            push;
  lae_pkg::entry_t push_data;
  logic            q_full;
  logic            q_valid;
  lae_pkg::entry_t q_data;

  lae_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .base_value (base_value),
    .offset_imm (offset_imm),
    .mem_low    (mem_low),
    .mem_high   (mem_high),
    .mem_fault  (mem_fault),
    .old_dest   (old_dest),
    .cop_usable (cop_usable),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  lae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_valid),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  lae_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (q_valid),
    .in_data        (q_data),
    .done           (done),
    .access_address (access_address),
    .access_size    (access_size),
    .write_enable   (write_enable),
    .to_float_file  (to_float_file),
    .result_low     (result_low),
    .result_high    (result_high),
    .status         (status)
  );

endmodule

`default_nettype wire
